@@ hw/rtl/radlw_pkg.sv @@
package radlw_pkg;

    // adler-32 modulus and the width that holds it
    localparam int unsigned    MOD_W      = 17;
    localparam logic [16:0]    ADLER_MOD  = 17'd65521;

    // window length register
    localparam int unsigned    CFG_W        = 13;
    localparam logic [12:0]    WINDOW_RESET = 13'd16;

    localparam int unsigned    SUM_W  = 16;
    localparam int unsigned    BYTE_W = 8;

    // adds that the result stage applies to the running sums
    typedef struct packed {
        logic [15:0] low_add;
        logic [15:0] high_add;
        logic        restart;
        logic        full;
    } sum_step_t;

endpackage

@@ hw/rtl/radlw_ram.sv @@
module radlw_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read returns the old word when both ports hit the same address
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ hw/rtl/rolling_adler32_window_unit.sv @@
// Rolling Adler-32 over the last window_length bytes of a byte stream. Each input beat carries
// one byte in s_axis_tdata and a restart flag in s_axis_tuser; restart clears the sums and the
// fill count, and that byte opens a new window. Each input beat yields exactly one output beat
// with the Adler-32 (modulus 65521) of the bytes now in the window, equal to zlib's value, and
// a window_full flag. While the window fills, the sums grow as plain Adler-32 from 1 and 0;
// once it is full each new byte rolls out the oldest one, read back from an internal ring
// store of MAX_WINDOW bytes. The block takes one beat per clock unless a stalled output has
// filled the pipeline: the ring store is written and read in the cycle a beat is accepted, the
// next stage forms the weight of the outgoing byte with one small multiply, and the last stage
// updates the sums. A stalled output only stops the pipeline once
// all three stages are occupied. window_length (1..MAX_WINDOW, 0 acts as 1, larger values
// saturate; reset value 16) is written through cfg_we / cfg_wdata and may be changed only
// while no beat is in flight; change it together with a restart to get a clean window.
module rolling_adler32_window_unit #(
    parameter int unsigned MAX_WINDOW = 4096
) (
    input  logic                           clk,
    input  logic                           rst_n,

    // window length register
    input  logic                           cfg_we,
    input  logic [radlw_pkg::CFG_W-1:0]    cfg_wdata,   // window_length

    // byte stream in
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,  // [7:0] data_byte
    input  logic                           s_axis_tuser,  // [0] restart

    // checksum stream out
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [31:0]                    m_axis_tdata,  // [31:0] checksum
    output logic                           m_axis_tuser   // [0] window_full
);

    // ring address width and the width that can hold MAX_WINDOW itself
    localparam int unsigned AW = $clog2(MAX_WINDOW);
    localparam int unsigned NW = $clog2(MAX_WINDOW + 1);
    localparam int unsigned PW = NW + radlw_pkg::BYTE_W;

    localparam logic [16:0] MOD = radlw_pkg::ADLER_MOD;

    // ------------------------------------------------------------------
    // window length register and effective length
    // ------------------------------------------------------------------
    logic [radlw_pkg::CFG_W-1:0] window_length_reg;
    logic [31:0]                 len_wide;
    logic [NW-1:0]               win_len;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg <= radlw_pkg::WINDOW_RESET;
        end
        else if (cfg_we)
        begin
            window_length_reg <= cfg_wdata;
        end
    end

    // zero acts as one byte, anything past the ring saturates
    always_comb
    begin
        len_wide = 32'(window_length_reg);
        if (len_wide == 32'd0)
        begin
            len_wide = 32'd1;
        end
        else if (len_wide > 32'(MAX_WINDOW))
        begin
            len_wide = 32'(MAX_WINDOW);
        end
        win_len = NW'(len_wide);
    end

    // ------------------------------------------------------------------
    // pipeline handshake: each stage moves when the one after it has room
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic out_valid_reg;
    logic load_out;
    logic load_s2;
    logic accept;

    assign load_out      = s2_valid_reg && (!out_valid_reg || m_axis_tready);
    assign load_s2       = s1_valid_reg && (!s2_valid_reg || load_out);
    assign s_axis_tready = !s1_valid_reg || load_s2;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // ------------------------------------------------------------------
    // stage 1: ring position, fill count, ring store write and read
    // ------------------------------------------------------------------
    logic [AW-1:0] ring_ptr_reg;
    logic [AW-1:0] ring_ptr_next;
    logic [NW-1:0] fill_count_reg;
    logic [NW-1:0] fill_count_next;
    logic [NW-1:0] pos_base;
    logic [NW-1:0] pos;
    logic [NW-1:0] pos_inc;
    logic [NW-1:0] fill_base;
    logic          filling;

    always_comb
    begin
        // restart sends pointer and fill count back to the start first
        pos_base  = s_axis_tuser ? '0 : NW'(ring_ptr_reg);
        fill_base = s_axis_tuser ? '0 : fill_count_reg;

        // a pointer left beyond a shortened window wraps to the start
        pos = (pos_base >= win_len) ? '0 : pos_base;

        pos_inc       = pos + NW'(1);
        ring_ptr_next = (pos_inc >= win_len) ? '0 : AW'(pos_inc);

        filling         = fill_base < win_len;
        fill_count_next = filling ? fill_base + NW'(1) : fill_base;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_ptr_reg   <= '0;
            fill_count_reg <= '0;
        end
        else if (accept)
        begin
            ring_ptr_reg   <= ring_ptr_next;
            fill_count_reg <= fill_count_next;
        end
    end

    // oldest byte comes back the cycle after the beat, new byte takes its slot
    logic [7:0] old_byte;

    radlw_ram #(
        .WIDTH (radlw_pkg::BYTE_W),
        .DEPTH (MAX_WINDOW)
    ) u_ring (
        .clk   (clk),
        .we    (accept),
        .waddr (AW'(pos)),
        .wdata (s_axis_tdata),
        .re    (accept),
        .raddr (AW'(pos)),
        .rdata (old_byte)
    );

    logic [7:0] s1_byte_reg;
    logic       s1_roll_reg;
    logic       s1_restart_reg;
    logic       s1_full_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            s1_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_byte_reg    <= s_axis_tdata;
            s1_roll_reg    <= !filling;
            s1_restart_reg <= s_axis_tuser;
            s1_full_reg    <= fill_count_next >= win_len;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: weight of the outgoing byte and the two sum increments
    // ------------------------------------------------------------------
    logic [PW-1:0]         weight_prod;
    logic [31:0]           prod_wide;
    logic [16:0]           weight_fold;
    logic [15:0]           weight;
    logic [16:0]           low_roll;
    logic [15:0]           low_roll_mod;
    radlw_pkg::sum_step_t  step_next;
    radlw_pkg::sum_step_t  s2_step_reg;

    always_comb
    begin
        // length times oldest byte, reduced using 2^16 = 15 mod 65521
        weight_prod = PW'(win_len) * PW'(old_byte);
        prod_wide   = 32'(weight_prod);
        weight_fold = 17'(prod_wide[15:0])
                    + 17'({prod_wide[23:16], 4'b0000})
                    - 17'(prod_wide[23:16]);
        weight      = (weight_fold >= MOD) ? 16'(weight_fold - MOD) : 16'(weight_fold);

        // new byte minus oldest byte, kept in 0..65520
        low_roll     = 17'(s1_byte_reg) + MOD - 17'(old_byte);
        low_roll_mod = (low_roll >= MOD) ? 16'(low_roll - MOD) : 16'(low_roll);

        step_next.restart = s1_restart_reg;
        step_next.full    = s1_full_reg;
        if (s1_roll_reg)
        begin
            // high sum loses the weight and the starting 1
            step_next.low_add  = low_roll_mod;
            step_next.high_add = 16'(MOD - 17'd1 - 17'(weight));
        end
        else
        begin
            step_next.low_add  = 16'(s1_byte_reg);
            step_next.high_add = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (!s2_valid_reg || load_out)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_s2)
        begin
            s2_step_reg <= step_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: running sums, which are also the output register
    // ------------------------------------------------------------------
    logic [15:0] sum_low_reg;
    logic [15:0] sum_high_reg;
    logic [15:0] sum_low_next;
    logic [15:0] sum_high_next;
    logic        out_full_reg;
    logic [15:0] low_base;
    logic [15:0] high_base;
    logic [16:0] low_acc;
    logic [17:0] high_acc;
    logic [17:0] high_once;

    always_comb
    begin
        low_base  = s2_step_reg.restart ? 16'd1 : sum_low_reg;
        high_base = s2_step_reg.restart ? 16'd0 : sum_high_reg;

        low_acc      = 17'(low_base) + 17'(s2_step_reg.low_add);
        sum_low_next = (low_acc >= MOD) ? 16'(low_acc - MOD) : 16'(low_acc);

        // three terms below the modulus, at most two subtracts
        high_acc  = 18'(high_base) + 18'(s2_step_reg.high_add) + 18'(sum_low_next);
        high_once = (high_acc >= 18'(MOD)) ? high_acc - 18'(MOD) : high_acc;
        sum_high_next = (high_once >= 18'(MOD)) ? 16'(high_once - 18'(MOD)) : 16'(high_once);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            sum_low_reg   <= 16'd1;
            sum_high_reg  <= 16'd0;
        end
        else
        begin
            if (!out_valid_reg || m_axis_tready)
            begin
                out_valid_reg <= s2_valid_reg;
            end
            if (load_out)
            begin
                sum_low_reg  <= sum_low_next;
                sum_high_reg <= sum_high_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_full_reg <= s2_step_reg.full;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {sum_high_reg, sum_low_reg};
    assign m_axis_tuser  = out_full_reg;

endmodule
